// ===== hdl/swts_pkg.sv =====
// shared types, constants and microcode table for the temperature window statistics block
package swts_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SAMPLE_W     = 12;
    localparam int TOTAL_W      = 17;
    localparam int STAMP_W      = 16;
    localparam int WSEC_W       = 4;
    localparam int TEMP_W       = 14;
    localparam int QUO_W        = 16;
    localparam int STEP_W       = 4;

    localparam logic [WSEC_W-1:0] WSEC_RESET = 4'd10;

    // x*9/5 by reciprocal multiply: floor(m * 26215 / 2^17) is exact for m below 2^15
    localparam logic [14:0] FAHR_RECIP  = 15'd26215;
    localparam int          FAHR_SHIFT  = 17;
    localparam logic signed [TEMP_W-1:0] FAHR_OFFSET = 14'sd512;

    localparam logic [0:0] REG_WINDOW_SECONDS  = 1'b0;
    localparam logic [0:0] REG_FAHRENHEIT_MODE = 1'b1;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_UPDATE    = 4'd2,
        OP_EXPIRE    = 4'd3,
        OP_SCAN_INIT = 4'd4,
        OP_SCAN      = 4'd5,
        OP_DIV_INIT  = 4'd6,
        OP_DIV       = 4'd7,
        OP_DIV_FIN   = 4'd8,
        OP_CONV      = 4'd9,
        OP_OUT       = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        SEL_CUR = 2'd0,
        SEL_AVG = 2'd1,
        SEL_MAX = 2'd2,
        SEL_MIN = 2'd3
    } conv_sel_t;

    typedef enum logic [2:0] {
        COND_NONE        = 3'd0,
        COND_ALWAYS      = 3'd1,
        COND_NO_ACCEPT   = 3'd2,
        COND_EXPIRE      = 3'd3,
        COND_SCAN_MORE   = 3'd4,
        COND_DIV_MORE    = 3'd5,
        COND_OUT_BLOCKED = 3'd6
    } cond_t;

    typedef struct packed {
        op_t              op;
        conv_sel_t        sel;
        cond_t            cond;
        logic [STEP_W-1:0] jmp;
    } ctrl_t;

    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_UPDATE    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_EXPIRE    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SCAN_INIT = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SCAN      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DIV_INIT  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIV       = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DIV_FIN   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CONV_CUR  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CONV_AVG  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CONV_MAX  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_CONV_MIN  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_OUT       = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DONE      = 4'd13;

    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{op: OP_NOP, sel: SEL_CUR, cond: COND_ALWAYS, jmp: STEP_IDLE};
        unique case (step)
            STEP_IDLE:      w = '{op: OP_ACCEPT,    sel: SEL_CUR, cond: COND_NO_ACCEPT,
                                  jmp: STEP_IDLE};
            STEP_UPDATE:    w = '{op: OP_UPDATE,    sel: SEL_CUR, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_EXPIRE:    w = '{op: OP_EXPIRE,    sel: SEL_CUR, cond: COND_EXPIRE,
                                  jmp: STEP_EXPIRE};
            STEP_SCAN_INIT: w = '{op: OP_SCAN_INIT, sel: SEL_CUR, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_SCAN:      w = '{op: OP_SCAN,      sel: SEL_CUR, cond: COND_SCAN_MORE,
                                  jmp: STEP_SCAN};
            STEP_DIV_INIT:  w = '{op: OP_DIV_INIT,  sel: SEL_CUR, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_DIV:       w = '{op: OP_DIV,       sel: SEL_CUR, cond: COND_DIV_MORE,
                                  jmp: STEP_DIV};
            STEP_DIV_FIN:   w = '{op: OP_DIV_FIN,   sel: SEL_CUR, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_CONV_CUR:  w = '{op: OP_CONV,      sel: SEL_CUR, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_CONV_AVG:  w = '{op: OP_CONV,      sel: SEL_AVG, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_CONV_MAX:  w = '{op: OP_CONV,      sel: SEL_MAX, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_CONV_MIN:  w = '{op: OP_CONV,      sel: SEL_MIN, cond: COND_NONE,
                                  jmp: STEP_IDLE};
            STEP_OUT:       w = '{op: OP_OUT,       sel: SEL_CUR, cond: COND_OUT_BLOCKED,
                                  jmp: STEP_OUT};
            default:        w = '{op: OP_NOP,       sel: SEL_CUR, cond: COND_ALWAYS,
                                  jmp: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/sliding_window_temp_stats.sv =====
// top level: microcoded sequencer computing window latest, average, max, min and count
// flow: one item at a time; the next word is taken only after the result is loaded
// reset: rst_n clears count, oldest pointer, total, latest reading and tick counter;
//   window_seconds returns to 10 and fahrenheit_mode to 0; ring contents are not cleared
module sliding_window_temp_stats
    import swts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] sample_value
    input  logic [0:0]  s_tuser,    // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // current_temp, average_temp, max_temp, min_temp,
                                    // sample_count, window_overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WSEC_W-1:0] wsec_reg;
    logic              fahr_reg;

    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             cw;

    logic                       type_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [STAMP_W-1:0]         tick_reg, tick_next;
    logic [PTR_W-1:0]           oldest_reg, oldest_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [TOTAL_W-1:0]  total_reg, total_next;
    logic signed [SAMPLE_W-1:0] latest_reg, latest_next;
    logic                       ovf_reg, ovf_next;

    logic [PTR_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           left_reg, left_next;
    logic signed [SAMPLE_W-1:0] mx_reg, mx_next, mn_reg, mn_next;

    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic                       neg_reg, neg_next;
    logic [3:0]                 dcnt_reg, dcnt_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;

    logic signed [TEMP_W-1:0]   cur_u_reg, avg_u_reg, mx_u_reg, mn_u_reg;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg;

    logic signed [SAMPLE_W-1:0] sample_ring [WINDOW_DEPTH];
    logic [STAMP_W-1:0]         stamp_ring  [WINDOW_DEPTH];

    logic [PTR_W-1:0]           rd_addr;
    logic signed [SAMPLE_W-1:0] rd_sample;
    logic [STAMP_W-1:0]         age;
    logic                       ring_full, expire_hit, in_accept, out_free, cond_true;
    logic                       ring_we;
    logic [PTR_W-1:0]           slot;
    logic [CNT_W:0]             trial;
    logic [TOTAL_W-1:0]         total_abs;
    logic [12:0]                avg_mag;
    logic signed [SAMPLE_W-1:0] conv_in;
    logic signed [TEMP_W-1:0]   conv_out;
    logic                       cfg_we;

    swts_to_unit u_conv
    (
        .fahr (fahr_reg),
        .x    (conv_in),
        .y    (conv_out)
    );

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[2:2])
            REG_WINDOW_SECONDS:  prdata = {28'd0, wsec_reg};
            REG_FAHRENHEIT_MODE: prdata = {31'd0, fahr_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsec_reg <= WSEC_RESET;
            fahr_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (paddr[2:2] == REG_WINDOW_SECONDS)
            begin
                wsec_reg <= pwdata[WSEC_W-1:0];
            end
            else
            begin
                fahr_reg <= pwdata[0];
            end
        end
    end

    assign cw        = ucode_rom(step_reg);
    assign s_tready  = (cw.op == OP_ACCEPT);
    assign in_accept = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign rd_addr    = (cw.op == OP_SCAN) ? idx_reg : oldest_reg;
    assign rd_sample  = sample_ring[rd_addr];
    assign age        = tick_reg - stamp_ring[oldest_reg];
    assign ring_full  = (count_reg == CNT_W'(WINDOW_DEPTH));
    assign expire_hit = (count_reg != '0) && (age > STAMP_W'(wsec_reg));
    assign slot       = oldest_reg + count_reg[PTR_W-1:0];
    assign ring_we    = (cw.op == OP_UPDATE) && (type_reg == REQ_SAMPLE);
    assign trial      = {rem_reg, quo_reg[QUO_W-1]};
    assign total_abs  = total_reg[TOTAL_W-1] ? -total_reg : total_reg;
    assign avg_mag    = neg_reg ? -quo_reg[12:0] : quo_reg[12:0];

    always_comb
    begin
        unique case (cw.sel)
            SEL_CUR: conv_in = latest_reg;
            SEL_AVG: conv_in = avg_reg;
            SEL_MAX: conv_in = mx_reg;
            SEL_MIN: conv_in = mn_reg;
            default: conv_in = latest_reg;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            COND_NONE:        cond_true = 1'b0;
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_ACCEPT:   cond_true = ~in_accept;
            COND_EXPIRE:      cond_true = expire_hit;
            COND_SCAN_MORE:   cond_true = (left_reg > CNT_W'(1));
            COND_DIV_MORE:    cond_true = (dcnt_reg != '0);
            COND_OUT_BLOCKED: cond_true = ~out_free;
            default:          cond_true = 1'b0;
        endcase
        step_next = cond_true ? cw.jmp : step_reg + STEP_W'(1);
    end

    always_comb
    begin
        tick_next     = tick_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        latest_next   = latest_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        left_next     = left_reg;
        mx_next       = mx_reg;
        mn_next       = mn_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        avg_next      = avg_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        unique case (cw.op)
            OP_ACCEPT:
            begin
                ovf_next = 1'b0;
            end
            OP_UPDATE:
            begin
                if (type_reg == REQ_TICK)
                begin
                    tick_next = tick_reg + STAMP_W'(1);
                end
                else
                begin
                    latest_next = samp_reg;
                    if (ring_full)
                    begin
                        total_next  = total_reg - TOTAL_W'(rd_sample) + TOTAL_W'(samp_reg);
                        oldest_next = oldest_reg + PTR_W'(1);
                        ovf_next    = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + TOTAL_W'(samp_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            OP_EXPIRE:
            begin
                if (expire_hit)
                begin
                    total_next  = total_reg - TOTAL_W'(rd_sample);
                    oldest_next = oldest_reg + PTR_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            OP_SCAN_INIT:
            begin
                idx_next  = oldest_reg;
                left_next = count_reg;
                mx_next   = rd_sample;
                mn_next   = rd_sample;
            end
            OP_SCAN:
            begin
                if (rd_sample > mx_reg)
                begin
                    mx_next = rd_sample;
                end
                if (rd_sample < mn_reg)
                begin
                    mn_next = rd_sample;
                end
                idx_next  = idx_reg + PTR_W'(1);
                left_next = left_reg - CNT_W'(1);
            end
            OP_DIV_INIT:
            begin
                neg_next  = total_reg[TOTAL_W-1];
                quo_next  = total_abs[QUO_W-1:0];
                rem_next  = '0;
                dcnt_next = 4'd15;
            end
            OP_DIV:
            begin
                if (trial >= {1'b0, count_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, count_reg});
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 4'd1;
            end
            OP_DIV_FIN:
            begin
                avg_next = $signed(avg_mag[SAMPLE_W-1:0]);
            end
            OP_CONV:
            begin
            end
            OP_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_IDLE;
            tick_reg     <= '0;
            oldest_reg   <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            latest_reg   <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            tick_reg     <= tick_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            latest_reg   <= latest_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg <= s_tuser[0];
            samp_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
        end
        idx_reg  <= idx_next;
        left_reg <= left_next;
        mx_reg   <= mx_next;
        mn_reg   <= mn_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
        dcnt_reg <= dcnt_next;
        avg_reg  <= avg_next;
        if (cw.op == OP_CONV)
        begin
            unique case (cw.sel)
                SEL_CUR: cur_u_reg <= conv_out;
                SEL_AVG: avg_u_reg <= conv_out;
                SEL_MAX: mx_u_reg  <= conv_out;
                SEL_MIN: mn_u_reg  <= conv_out;
                default: cur_u_reg <= conv_out;
            endcase
        end
        if ((cw.op == OP_OUT) && out_free)
        begin
            if (count_reg == '0)
            begin
                m_tdata_reg <= {2'b00, ovf_reg, count_reg, 42'd0, cur_u_reg};
            end
            else
            begin
                m_tdata_reg <= {2'b00, ovf_reg, count_reg, mn_u_reg, mx_u_reg,
                                avg_u_reg, cur_u_reg};
            end
        end
    end

    // sample and stamp rings
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            sample_ring[slot] <= samp_reg;
            stamp_ring[slot]  <= tick_reg;
        end
    end

endmodule

// ===== hdl/swts_to_unit.sv =====
// celsius to selected unit conversion, fahrenheit as x*9/5+512 truncated toward zero
module swts_to_unit
    import swts_pkg::*;
(
    input  logic                       fahr,
    input  logic signed [SAMPLE_W-1:0] x,
    output logic signed [TEMP_W-1:0]   y
);

    logic signed [15:0] x9;
    logic        [14:0] mag;
    logic        [29:0] prod;
    logic        [12:0] quo;
    logic signed [TEMP_W-1:0] sq;

    always_comb
    begin
        x9   = (16'(x) <<< 3) + 16'(x);
        mag  = x9[15] ? 15'(-x9) : x9[14:0];
        prod = 30'(mag) * 30'(FAHR_RECIP);
        quo  = prod[FAHR_SHIFT +: 13];
        sq   = x9[15] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (fahr)
        begin
            y = sq + FAHR_OFFSET;
        end
        else
        begin
            y = TEMP_W'(x);
        end
    end

endmodule
